>>> hw/rtl/triangle_plane_slice_segment_unit_defines.svh
// Assertion helpers shared by the slicing unit.
`ifndef TRIANGLE_PLANE_SLICE_SEGMENT_UNIT_DEFINES_SVH
`define TRIANGLE_PLANE_SLICE_SEGMENT_UNIT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define TPSS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Fixed-delay implication, checked only out of reset.
`define TPSS_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tpss_pkg.sv
package tpss_pkg;

    localparam int COORD_W   = 21;
    localparam int UNIT_FRAC = 19;
    localparam int SLOT_W    = UNIT_FRAC + 2;
    localparam int VEC_W     = 3 * SLOT_W;
    localparam int TOL_W     = 8;
    localparam int DIST_DROP = 4;

    // plane distance: three coordinate-by-unit products minus the offset term
    localparam int PROD_W  = COORD_W + SLOT_W;
    localparam int DIST_W  = PROD_W + 2;
    localparam int E_W     = DIST_W - DIST_DROP;
    localparam int DEN_W   = E_W + 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int EL_W    = E_W / 2;
    localparam int EH_W    = E_W - EL_W;
    localparam int PH_W    = EH_W + DIFF_W;
    localparam int PL_W    = EL_W + 1 + DIFF_W;
    localparam int NUM_W   = E_W + DIFF_W;
    localparam int QUO_W   = COORD_W;
    localparam int DIV_LAT = QUO_W + 1;

    localparam int PPROD_W = COORD_W + SLOT_W;
    localparam int PSUM_W  = PPROD_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VEC_W;

    localparam int DIST_STAGES = 2;
    localparam int EDGE_STAGES = 3;
    localparam int PROJ_STAGES = 3;
    localparam int PIPE_LAT    = DIST_STAGES + EDGE_STAGES + DIV_LAT + PROJ_STAGES;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SLOT_W-1:0]  unit_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL,
        CFG_OFFSET,
        CFG_BASIS_U,
        CFG_BASIS_V,
        CFG_ON_TOL,
        CFG_EQ_TOL
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic final_tri;
        logic two_pts;
    } ctl_t;

    typedef struct packed {
        logic [NUM_W-1:0] num_mag;
        logic [DEN_W-1:0] den_mag;
        logic             neg;
        coord_t           v1;
    } lane_t;

endpackage

>>> hw/rtl/tpss_dist.sv
// Plane distance of the three vertices: products, then sum minus offset.
module tpss_dist (
    input  logic              clk,
    input  logic              rst_n,
    input  tpss_pkg::ctl_t    ctl_in,
    input  tpss_pkg::coord_t  vtx_in [3][3],
    input  tpss_pkg::unit_t   nrm [3],
    input  tpss_pkg::coord_t  offset,
    output tpss_pkg::ctl_t    ctl_out,
    output tpss_pkg::coord_t  vtx_out [3][3],
    output logic signed [tpss_pkg::DIST_W-1:0] dist_out [3]
);

    tpss_pkg::ctl_t   ctl1_reg;
    tpss_pkg::coord_t vtx1_reg [3][3];
    logic signed [tpss_pkg::PROD_W-1:0] prod_reg [3][3];
    tpss_pkg::ctl_t   ctl2_reg;
    tpss_pkg::coord_t vtx2_reg [3][3];
    logic signed [tpss_pkg::DIST_W-1:0] dist_reg [3];
    logic signed [tpss_pkg::DIST_W-1:0] off_full;

    assign off_full = tpss_pkg::DIST_W'(offset) <<< tpss_pkg::UNIT_FRAC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vtx1_reg[i][k] <= vtx_in[i][k];
                prod_reg[i][k] <= vtx_in[i][k] * nrm[k];
                vtx2_reg[i][k] <= vtx1_reg[i][k];
            end
            dist_reg[i] <= tpss_pkg::DIST_W'(prod_reg[i][0])
                         + tpss_pkg::DIST_W'(prod_reg[i][1])
                         + tpss_pkg::DIST_W'(prod_reg[i][2]) - off_full;
        end
    end

    assign ctl_out  = ctl2_reg;
    assign vtx_out  = vtx2_reg;
    assign dist_out = dist_reg;

endmodule

>>> hw/rtl/tpss_edge.sv
// Edge classification, point slot selection and numerator build.
module tpss_edge (
    input  logic              clk,
    input  logic              rst_n,
    input  tpss_pkg::ctl_t    ctl_in,
    input  tpss_pkg::coord_t  vtx [3][3],
    input  logic signed [tpss_pkg::DIST_W-1:0] plane_dist [3],
    input  logic [tpss_pkg::TOL_W-1:0] on_tol,
    output tpss_pkg::ctl_t    ctl_out,
    output tpss_pkg::lane_t   lane_out [2][3]
);

    localparam int DW = tpss_pkg::DIST_W;

    logic                              take [3];
    tpss_pkg::coord_t                  cand_v1 [3][3];
    logic signed [tpss_pkg::DIFF_W-1:0] cand_diff [3][3];
    logic signed [tpss_pkg::E_W-1:0]   cand_e1 [3];
    logic signed [tpss_pkg::DEN_W-1:0] cand_den [3];
    logic [DW-1:0]                     tol_full;
    logic [1:0]                        sel0;
    logic [1:0]                        sel1;
    logic [1:0]                        take_cnt;

    tpss_pkg::ctl_t                     ctl3_reg;
    tpss_pkg::coord_t                   v1_reg [2][3];
    logic signed [tpss_pkg::DIFF_W-1:0] diff_reg [2][3];
    logic signed [tpss_pkg::E_W-1:0]    e1_reg [2];
    logic signed [tpss_pkg::DEN_W-1:0]  den_reg [2];

    tpss_pkg::ctl_t                     ctl4_reg;
    tpss_pkg::coord_t                   v1b_reg [2][3];
    logic signed [tpss_pkg::PH_W-1:0]   ph_reg [2][3];
    logic signed [tpss_pkg::PL_W-1:0]   pl_reg [2][3];
    logic signed [tpss_pkg::DEN_W-1:0]  denb_reg [2];

    tpss_pkg::ctl_t                     ctl5_reg;
    tpss_pkg::lane_t                    lane_reg [2][3];

    assign tol_full = DW'(on_tol) << tpss_pkg::UNIT_FRAC;

    for (genvar i = 0; i < 3; i++)
    begin : g_edge
        localparam int J = (i + 1) % 3;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
        logic [DW-1:0]        abs1;
        logic                 crossing;
        logic                 on_plane;
        logic signed [tpss_pkg::E_W-1:0] e1;
        logic signed [tpss_pkg::E_W-1:0] e2;

        assign d1 = plane_dist[i];
        assign d2 = plane_dist[J];
        assign abs1 = d1[DW-1] ? DW'(-d1) : DW'(d1);
        assign crossing = (d1[DW-1] && !d2[DW-1] && (d2 != '0))
                       || (!d1[DW-1] && (d1 != '0) && d2[DW-1]);
        assign on_plane = !crossing && (abs1 < tol_full);
        // floor division by a power of two is the upper bits
        assign e1 = $signed(d1[DW-1:tpss_pkg::DIST_DROP]);
        assign e2 = $signed(d2[DW-1:tpss_pkg::DIST_DROP]);
        assign take[i] = crossing || on_plane;
        // a vertex on the plane goes through as v1 + 0/1
        assign cand_e1[i]  = crossing ? e1 : '0;
        assign cand_den[i] = crossing ? (tpss_pkg::DEN_W'(e1) - tpss_pkg::DEN_W'(e2))
                                      : tpss_pkg::DEN_W'(1);
        for (genvar k = 0; k < 3; k++)
        begin : g_axis
            assign cand_v1[i][k]   = vtx[i][k];
            assign cand_diff[i][k] = crossing ? (tpss_pkg::DIFF_W'(vtx[J][k])
                                               - tpss_pkg::DIFF_W'(vtx[i][k])) : '0;
        end
    end

    always_comb
    begin
        take_cnt = 2'(take[0]) + 2'(take[1]) + 2'(take[2]);
        sel0 = take[0] ? 2'd0 : (take[1] ? 2'd1 : 2'd2);
        sel1 = (take[0] && take[1]) ? 2'd1 : 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else
        begin
            ctl3_reg.valid     <= ctl_in.valid;
            ctl3_reg.final_tri <= ctl_in.final_tri;
            ctl3_reg.two_pts   <= (take_cnt == 2'd2);
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg[0]  <= cand_e1[sel0];
        e1_reg[1]  <= cand_e1[sel1];
        den_reg[0] <= cand_den[sel0];
        den_reg[1] <= cand_den[sel1];
        for (int k = 0; k < 3; k++)
        begin
            v1_reg[0][k]   <= cand_v1[sel0][k];
            v1_reg[1][k]   <= cand_v1[sel1][k];
            diff_reg[0][k] <= cand_diff[sel0][k];
            diff_reg[1][k] <= cand_diff[sel1][k];
        end
    end

    // split the wide distance so each multiplier stays narrow
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 2; p++)
        begin
            denb_reg[p] <= den_reg[p];
            for (int k = 0; k < 3; k++)
            begin
                v1b_reg[p][k] <= v1_reg[p][k];
                ph_reg[p][k]  <= $signed(e1_reg[p][tpss_pkg::E_W-1:tpss_pkg::EL_W])
                               * diff_reg[p][k];
                pl_reg[p][k]  <= $signed({1'b0, e1_reg[p][tpss_pkg::EL_W-1:0]})
                               * diff_reg[p][k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [tpss_pkg::NUM_W-1:0] num;
                num = (tpss_pkg::NUM_W'(ph_reg[p][k]) <<< tpss_pkg::EL_W)
                    + tpss_pkg::NUM_W'(pl_reg[p][k]);
                lane_reg[p][k].num_mag <= num[tpss_pkg::NUM_W-1] ? tpss_pkg::NUM_W'(-num)
                                                                 : tpss_pkg::NUM_W'(num);
                lane_reg[p][k].den_mag <= denb_reg[p][tpss_pkg::DEN_W-1]
                                        ? tpss_pkg::DEN_W'(-denb_reg[p])
                                        : tpss_pkg::DEN_W'(denb_reg[p]);
                lane_reg[p][k].neg <= num[tpss_pkg::NUM_W-1]
                                    ^ denb_reg[p][tpss_pkg::DEN_W-1];
                lane_reg[p][k].v1  <= v1b_reg[p][k];
            end
        end
    end

    assign ctl_out  = ctl5_reg;
    assign lane_out = lane_reg;

endmodule

>>> hw/rtl/tpss_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage, then v1 + q.
module tpss_div_lane (
    input  logic             clk,
    input  tpss_pkg::lane_t  lane_in,
    output tpss_pkg::coord_t coord_out
);

    localparam int NW = tpss_pkg::NUM_W;
    localparam int QW = tpss_pkg::QUO_W;

    logic [NW-1:0]                 rem_reg [QW];
    logic [QW-1:0]                 q_reg [QW];
    logic [tpss_pkg::DEN_W-1:0]    den_reg [QW];
    logic                          neg_reg [QW];
    tpss_pkg::coord_t              v1_reg [QW];
    tpss_pkg::coord_t              coord_reg;
    logic signed [QW:0]            q_signed;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [NW-1:0]              rem_prev;
        logic [QW-1:0]              q_prev;
        logic [tpss_pkg::DEN_W-1:0] den_prev;
        logic                       neg_prev;
        tpss_pkg::coord_t           v1_prev;
        logic [NW:0]                trial;

        if (s == 0)
        begin : g_first
            assign rem_prev = lane_in.num_mag;
            assign q_prev   = '0;
            assign den_prev = lane_in.den_mag;
            assign neg_prev = lane_in.neg;
            assign v1_prev  = lane_in.v1;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[s-1];
            assign q_prev   = q_reg[s-1];
            assign den_prev = den_reg[s-1];
            assign neg_prev = neg_reg[s-1];
            assign v1_prev  = v1_reg[s-1];
        end

        assign trial = (NW+1)'(den_prev) << (QW - 1 - s);

        always_ff @(posedge clk)
        begin
            if ({1'b0, rem_prev} >= trial)
            begin
                rem_reg[s] <= rem_prev - trial[NW-1:0];
                q_reg[s]   <= q_prev | (QW'(1) << (QW - 1 - s));
            end
            else
            begin
                rem_reg[s] <= rem_prev;
                q_reg[s]   <= q_prev;
            end
            den_reg[s] <= den_prev;
            neg_reg[s] <= neg_prev;
            v1_reg[s]  <= v1_prev;
        end
    end

    assign q_signed = neg_reg[QW-1] ? -$signed({1'b0, q_reg[QW-1]})
                                    : $signed({1'b0, q_reg[QW-1]});

    always_ff @(posedge clk)
    begin
        coord_reg <= tpss_pkg::COORD_W'(v1_reg[QW-1] + q_signed);
    end

    assign coord_out = coord_reg;

endmodule

>>> hw/rtl/tpss_proj.sv
// Projection onto the basis, truncation, saturation, equality test, result.
module tpss_proj (
    input  logic              clk,
    input  logic              rst_n,
    input  tpss_pkg::ctl_t    ctl_in,
    input  tpss_pkg::coord_t  pt [2][3],
    input  tpss_pkg::unit_t   basis [2][3],
    input  logic [tpss_pkg::TOL_W-1:0] eq_tol,
    output logic              res_valid,
    output logic              res_hit,
    output tpss_pkg::coord_t  res_uv [2][2],
    output logic              res_final
);

    localparam int SW = tpss_pkg::PSUM_W;
    localparam int CW = tpss_pkg::COORD_W;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (CW - 1)));
    localparam logic signed [SW-1:0] TRUNC_BIAS =
        SW'((64'sd1 <<< tpss_pkg::UNIT_FRAC) - 64'sd1);

    tpss_pkg::ctl_t ctl1_reg;
    tpss_pkg::ctl_t ctl2_reg;
    logic signed [tpss_pkg::PPROD_W-1:0] prod_reg [2][2][3];
    tpss_pkg::coord_t proj_reg [2][2];
    logic             valid_reg;
    logic             hit_reg;
    logic             final_reg;
    tpss_pkg::coord_t uv_reg [2][2];
    logic             same;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg  <= ctl_in;
            ctl2_reg  <= ctl1_reg;
            valid_reg <= ctl2_reg.valid;
            hit_reg   <= ctl2_reg.valid && ctl2_reg.two_pts && !same;
            final_reg <= ctl2_reg.valid && ctl2_reg.final_tri;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 2; p++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[p][b][k] <= pt[p][k] * basis[b][k];
                end
            end
        end
    end

    // truncate toward zero, then clamp to the coordinate range
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 2; p++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                logic signed [SW-1:0] sum;
                logic signed [SW-1:0] biased;
                logic signed [SW-1:0] shifted;
                sum = SW'(prod_reg[p][b][0]) + SW'(prod_reg[p][b][1])
                    + SW'(prod_reg[p][b][2]);
                biased = sum[SW-1] ? (sum + TRUNC_BIAS) : sum;
                shifted = biased >>> tpss_pkg::UNIT_FRAC;
                if (shifted > SAT_HI)
                begin
                    proj_reg[p][b] <= CW'(SAT_HI);
                end
                else if (shifted < SAT_LO)
                begin
                    proj_reg[p][b] <= CW'(SAT_LO);
                end
                else
                begin
                    proj_reg[p][b] <= CW'(shifted);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [CW:0] du;
        logic signed [CW:0] dv;
        logic [CW:0]        adu;
        logic [CW:0]        adv;
        du  = (CW+1)'(proj_reg[0][0]) - (CW+1)'(proj_reg[1][0]);
        dv  = (CW+1)'(proj_reg[0][1]) - (CW+1)'(proj_reg[1][1]);
        adu = du[CW] ? (CW+1)'(-du) : (CW+1)'(du);
        adv = dv[CW] ? (CW+1)'(-dv) : (CW+1)'(dv);
        same = (adu < (CW+1)'(eq_tol)) && (adv < (CW+1)'(eq_tol));
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 2; p++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                uv_reg[p][b] <= (ctl2_reg.two_pts && !same) ? proj_reg[p][b] : '0;
            end
        end
    end

    assign res_valid = valid_reg;
    assign res_hit   = hit_reg;
    assign res_final = final_reg;
    assign res_uv    = uv_reg;

endmodule

>>> hw/rtl/triangle_plane_slice_segment_unit.sv
// Triangle / plane slicing unit.
// Command channel: present the three vertices and final_triangle with start
// high; a transaction is taken at every rising edge where start is high and
// busy is low. busy stays low, so a new triangle may be issued every cycle.
// Result channel: done is high for one cycle per triangle, carrying
// segment_hit, the projected ends start_u/start_v/end_u/end_v (zero when
// there is no hit) and final_segment. Results come out in issue order.
// Pipeline: an accepted triangle passes the distance, edge select, divider
// and projection stages in that order before done; throughput one triangle per
// cycle, set by the fully pipelined per-bit divider lanes.
// Configuration: cfg_we with cfg_addr/cfg_wdata writes one register per
// cycle; write only while no triangle is in flight.
// Reset: rst_n clears the in-flight valid bits and loads the default plane
// z = 0 with basis x, y and zero tolerances.
// The receiver cannot stall; the pipeline never holds.
`include "triangle_plane_slice_segment_unit_defines.svh"

module triangle_plane_slice_segment_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_a_x,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_a_y,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_a_z,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_b_x,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_b_y,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_b_z,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_c_x,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_c_y,
    input  logic signed [tpss_pkg::COORD_W-1:0] vertex_c_z,
    input  logic final_triangle,
    output logic done,
    output logic segment_hit,
    output logic signed [tpss_pkg::COORD_W-1:0] start_u,
    output logic signed [tpss_pkg::COORD_W-1:0] start_v,
    output logic signed [tpss_pkg::COORD_W-1:0] end_u,
    output logic signed [tpss_pkg::COORD_W-1:0] end_v,
    output logic final_segment,
    input  logic cfg_we,
    input  logic [tpss_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [tpss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SW = tpss_pkg::SLOT_W;

    logic [tpss_pkg::VEC_W-1:0]   normal_reg;
    tpss_pkg::coord_t             offset_reg;
    logic [tpss_pkg::VEC_W-1:0]   basis_u_reg;
    logic [tpss_pkg::VEC_W-1:0]   basis_v_reg;
    logic [tpss_pkg::TOL_W-1:0]   on_tol_reg;
    logic [tpss_pkg::TOL_W-1:0]   eq_tol_reg;

    tpss_pkg::unit_t   nrm [3];
    tpss_pkg::unit_t   basis [2][3];
    tpss_pkg::coord_t  vtx_in [3][3];
    tpss_pkg::ctl_t    ctl_in;
    tpss_pkg::ctl_t    dist_ctl;
    tpss_pkg::coord_t  dist_vtx [3][3];
    logic signed [tpss_pkg::DIST_W-1:0] plane_dist [3];
    tpss_pkg::ctl_t    edge_ctl;
    tpss_pkg::lane_t   lanes [2][3];
    tpss_pkg::coord_t  pts [2][3];
    tpss_pkg::ctl_t    div_ctl_reg [tpss_pkg::DIV_LAT];
    tpss_pkg::coord_t  res_uv [2][2];

    // Config writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg  <= tpss_pkg::VEC_W'(1) << (2 * SW + tpss_pkg::UNIT_FRAC);
            offset_reg  <= '0;
            basis_u_reg <= tpss_pkg::VEC_W'(1) << tpss_pkg::UNIT_FRAC;
            basis_v_reg <= tpss_pkg::VEC_W'(1) << (SW + tpss_pkg::UNIT_FRAC);
            on_tol_reg  <= '0;
            eq_tol_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (tpss_pkg::cfg_idx_t'(cfg_addr))
                tpss_pkg::CFG_NORMAL:  normal_reg  <= cfg_wdata[tpss_pkg::VEC_W-1:0];
                tpss_pkg::CFG_OFFSET:  offset_reg  <= cfg_wdata[tpss_pkg::COORD_W-1:0];
                tpss_pkg::CFG_BASIS_U: basis_u_reg <= cfg_wdata[tpss_pkg::VEC_W-1:0];
                tpss_pkg::CFG_BASIS_V: basis_v_reg <= cfg_wdata[tpss_pkg::VEC_W-1:0];
                tpss_pkg::CFG_ON_TOL:  on_tol_reg  <= cfg_wdata[tpss_pkg::TOL_W-1:0];
                tpss_pkg::CFG_EQ_TOL:  eq_tol_reg  <= cfg_wdata[tpss_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the vector slots: x at the bottom, then y, then z.
    for (genvar k = 0; k < 3; k++)
    begin : g_unpack
        assign nrm[k]      = $signed(normal_reg[k*SW +: SW]);
        assign basis[0][k] = $signed(basis_u_reg[k*SW +: SW]);
        assign basis[1][k] = $signed(basis_v_reg[k*SW +: SW]);
    end

    assign vtx_in[0][0] = vertex_a_x;
    assign vtx_in[0][1] = vertex_a_y;
    assign vtx_in[0][2] = vertex_a_z;
    assign vtx_in[1][0] = vertex_b_x;
    assign vtx_in[1][1] = vertex_b_y;
    assign vtx_in[1][2] = vertex_b_z;
    assign vtx_in[2][0] = vertex_c_x;
    assign vtx_in[2][1] = vertex_c_y;
    assign vtx_in[2][2] = vertex_c_z;

    // Every stage advances every cycle, so the command side never waits.
    assign busy = 1'b0;

    assign ctl_in.valid     = start && !busy;
    assign ctl_in.final_tri = final_triangle;
    assign ctl_in.two_pts   = 1'b0;

    tpss_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_in),
        .vtx_in   (vtx_in),
        .nrm      (nrm),
        .offset   (offset_reg),
        .ctl_out  (dist_ctl),
        .vtx_out  (dist_vtx),
        .dist_out (plane_dist)
    );

    tpss_edge u_edge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (dist_ctl),
        .vtx        (dist_vtx),
        .plane_dist (plane_dist),
        .on_tol     (on_tol_reg),
        .ctl_out    (edge_ctl),
        .lane_out   (lanes)
    );

    // Six divider lanes: two collected points, three axes each.
    for (genvar p = 0; p < 2; p++)
    begin : g_pt
        for (genvar k = 0; k < 3; k++)
        begin : g_ax
            tpss_div_lane u_div (
                .clk       (clk),
                .lane_in   (lanes[p][k]),
                .coord_out (pts[p][k])
            );
        end
    end

    // Carry the valid bit and flags alongside the divider lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < tpss_pkg::DIV_LAT; s++)
            begin
                div_ctl_reg[s] <= '0;
            end
        end
        else
        begin
            div_ctl_reg[0] <= edge_ctl;
            for (int s = 1; s < tpss_pkg::DIV_LAT; s++)
            begin
                div_ctl_reg[s] <= div_ctl_reg[s-1];
            end
        end
    end

    tpss_proj u_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (div_ctl_reg[tpss_pkg::DIV_LAT-1]),
        .pt        (pts),
        .basis     (basis),
        .eq_tol    (eq_tol_reg),
        .res_valid (done),
        .res_hit   (segment_hit),
        .res_uv    (res_uv),
        .res_final (final_segment)
    );

    assign start_u = res_uv[0][0];
    assign start_v = res_uv[0][1];
    assign end_u   = res_uv[1][0];
    assign end_v   = res_uv[1][1];

    `TPSS_ASSERT_DELAY(a_fixed_latency, start && !busy, tpss_pkg::PIPE_LAT, done,
        "accepted triangle did not produce a result at the pipeline latency")
    `TPSS_ASSERT_IMPLIES(a_miss_zero, done && !segment_hit,
        start_u == '0 && start_v == '0 && end_u == '0 && end_v == '0,
        "result without a hit carries nonzero coordinates")
    `TPSS_ASSERT_IMPLIES(a_flags_need_done, !done, !segment_hit && !final_segment,
        "result flags raised without the result strobe")

endmodule
